FILE: hdl/arat_pkg.sv
// ----------------------------------------------------------------------------
// address range allocation table package
// shared constants, transaction types, record layout and codes
// ----------------------------------------------------------------------------
`default_nettype none

package arat_pkg;

    localparam int ENTRIES    = 64;
    localparam int HEAPS      = 4;
    localparam int ADDR_W     = 48;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGES_W    = 36;
    localparam int LIMIT_W    = 37;
    localparam int IDX_W      = $clog2(ENTRIES);
    localparam int LIVE_W     = $clog2(ENTRIES + 1);
    localparam int HEAP_W     = $clog2(HEAPS);
    localparam int BYTES_W    = 64;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64'h10_0000_0000);

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_RESIDENT = 3'd2,
        OP_EVICT    = 3'd3,
        OP_MAP      = 3'd4,
        OP_UNMAP    = 3'd5,
        OP_LOOKUP   = 3'd6,
        OP_UNUSED   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_LIMIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_OVERLAP  = 3'd4,
        ST_NOTFOUND = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_UPDATE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic [ADDR_W-1:0]  address;
        logic [PAGES_W-1:0] size_pages;
        logic [63:0]        timestamp;
        logic [1:0]         preferred_heap;
        logic [2:0]         owner;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         entry_index;
        logic [31:0]        serial;
        logic [4:0]         flags;
        logic [31:0]        resident_adds;
        logic [31:0]        evictions;
        logic [31:0]        map_depth;
        logic [ADDR_W-1:0]  range_base;
        logic [PAGES_W-1:0] range_pages;
        logic [63:0]        total_bytes;
        logic [63:0]        heap_bytes;
    } resp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic [4:0]         flags;
        logic [31:0]        serial;
        logic [HEAP_W-1:0]  heap;
        logic [2:0]         owner;
        logic [31:0]        res_adds;
        logic [31:0]        evictions;
        logic [31:0]        map_depth;
        logic [63:0]        t_create;
        logic [63:0]        t_res;
        logic [63:0]        t_map;
        logic [63:0]        t_unmap;
    } rec_t;

endpackage

`default_nettype wire

FILE: hdl/arat_table.sv
// ----------------------------------------------------------------------------
// range record store
// one write port, one registered read port, one record per slot
// ----------------------------------------------------------------------------
`default_nettype none

module arat_table (
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [arat_pkg::IDX_W-1:0] wr_idx,
    input  wire arat_pkg::rec_t          wr_row,
    input  wire logic [arat_pkg::IDX_W-1:0] rd_idx,
    output arat_pkg::rec_t               rd_row
);

    arat_pkg::rec_t mem [arat_pkg::ENTRIES];
    arat_pkg::rec_t rd_row_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_row;
        end
        rd_row_reg <= mem[rd_idx];
    end

    assign rd_row = rd_row_reg;

endmodule

`default_nettype wire

FILE: hdl/address_range_allocation_table.sv
// ----------------------------------------------------------------------------
// address range allocation table
// table of virtual address ranges with add, remove, residency, map and
// lookup transactions, searched one slot per cycle
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_item  (arat_pkg::req_t)
// out       output     out_valid/ out_stall out_item (arat_pkg::resp_t)
// cfg       input      cfg_write            cfg_data (page limit, 37 bits)
//
// a transaction runs through accept, a check state, a scan of the 64
// slots through the registered record store read port (one slot per
// cycle), an update state and a hand-over to the output register.
// adds rejected by the early checks and operation seven end after the
// check state. the scan stops at the first range that holds the address;
// an add that finds none runs over the whole table for the lowest free slot.
// reset clears valid bits, counters and totals at once; no clearing pass.
// a finished result waits in the output register while the next
// transaction is taken; in_stall is high while a transaction is at work.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_allocation_table (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire arat_pkg::req_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output arat_pkg::resp_t      out_item,
    input  wire logic            cfg_write,
    input  wire logic [arat_pkg::LIMIT_W-1:0] cfg_data
);

    localparam int IW = arat_pkg::IDX_W;

    // sequencer and request copy
    arat_pkg::state_t state_reg, state_next;
    logic [2:0]                     op_reg;
    logic [arat_pkg::ADDR_W-1:0]    addr_reg;
    logic [arat_pkg::PAGES_W-1:0]   size_reg;
    logic [63:0]                    ts_reg;
    logic [arat_pkg::HEAP_W-1:0]    heap_reg;
    logic [2:0]                     owner_reg;
    logic [arat_pkg::LIMIT_W-1:0]   limit_reg;

    // scan pipeline
    logic [IW-1:0] idx_reg, idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg;
    logic          free_found_reg, free_found_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    arat_pkg::rec_t row_reg, row_next;

    // table state
    logic [arat_pkg::ENTRIES-1:0]  valid_reg, valid_next;
    logic [arat_pkg::LIVE_W-1:0]   live_reg, live_next;
    logic [31:0]                   serial_reg, serial_next;
    logic [63:0]                   total_reg, total_next;
    logic [63:0]                   heap_bytes_reg [arat_pkg::HEAPS];
    logic [63:0]                   heap_sum_next;

    // result staging and output register
    arat_pkg::resp_t res_reg, res_next;
    arat_pkg::resp_t out_reg;
    logic            out_valid_reg, out_valid_next;

    // record store ports
    logic           tbl_we;
    logic [IW-1:0]  tbl_widx;
    arat_pkg::rec_t tbl_wrow;
    arat_pkg::rec_t tbl_rrow;

    arat_table u_table (
        .clk    (clk),
        .wr_en  (tbl_we),
        .wr_idx (tbl_widx),
        .wr_row (tbl_wrow),
        .rd_idx (idx_reg),
        .rd_row (tbl_rrow)
    );

    // early checks
    logic [arat_pkg::LIMIT_W-1:0] end_page;
    logic [2:0]                   chk_status;
    logic                         is_add;

    assign is_add   = (op_reg == arat_pkg::OP_ADD);
    assign end_page = {1'b0, addr_reg[arat_pkg::ADDR_W-1:arat_pkg::PAGE_SHIFT]}
                      + {1'b0, size_reg};

    always_comb
    begin
        chk_status = arat_pkg::ST_OK;
        priority if (op_reg == arat_pkg::OP_UNUSED)
            chk_status = arat_pkg::ST_NOTFOUND;
        else if (is_add && size_reg == '0)
            chk_status = arat_pkg::ST_ZERO;
        else if (is_add && end_page >= limit_reg)
            chk_status = arat_pkg::ST_LIMIT;
        else if (is_add && live_reg >= arat_pkg::LIVE_W'(arat_pkg::ENTRIES))
            chk_status = arat_pkg::ST_FULL;
        else
            chk_status = arat_pkg::ST_OK;
    end

    // containment compare on the slot read last cycle
    logic [arat_pkg::ADDR_W:0]   diff;
    logic [arat_pkg::ADDR_W-1:0] span;
    logic                        slot_valid, hit, last, free_now;

    assign diff       = {1'b0, addr_reg} - {1'b0, tbl_rrow.base};
    assign span       = {tbl_rrow.pages, {arat_pkg::PAGE_SHIFT{1'b0}}};
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign hit        = cmp_vld_reg && slot_valid && !diff[arat_pkg::ADDR_W]
                        && (diff[arat_pkg::ADDR_W-1:0] < span);
    assign last       = cmp_vld_reg && (cmp_idx_reg == IW'(arat_pkg::ENTRIES - 1));
    assign free_now   = cmp_vld_reg && !slot_valid;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            arat_pkg::S_IDLE:
                if (in_valid)
                    state_next = arat_pkg::S_CHECK;
            arat_pkg::S_CHECK:
                state_next = (chk_status == arat_pkg::ST_OK) ? arat_pkg::S_SCAN
                                                             : arat_pkg::S_DONE;
            arat_pkg::S_SCAN:
                if (hit)
                    state_next = is_add ? arat_pkg::S_DONE : arat_pkg::S_UPDATE;
                else if (last)
                    state_next = (is_add && (free_found_reg || free_now))
                                 ? arat_pkg::S_UPDATE : arat_pkg::S_DONE;
            arat_pkg::S_UPDATE:
                state_next = arat_pkg::S_DONE;
            arat_pkg::S_DONE:
                if (!out_valid_reg || !out_stall)
                    state_next = arat_pkg::S_IDLE;
            default:
                state_next = arat_pkg::S_IDLE;
        endcase
    end

    // new record for the update cycle
    arat_pkg::rec_t              upd_row;
    logic [IW-1:0]               upd_slot;
    logic [arat_pkg::HEAP_W-1:0] upd_heap;
    logic [63:0]                 upd_bytes;

    assign upd_slot  = is_add ? free_idx_reg : hit_idx_reg;
    assign upd_heap  = is_add ? heap_reg : row_reg.heap;
    assign upd_bytes = 64'({is_add ? size_reg : row_reg.pages,
                            {arat_pkg::PAGE_SHIFT{1'b0}}});

    always_comb
    begin
        upd_row = row_reg;
        unique case (op_reg)
            arat_pkg::OP_ADD:
            begin
                upd_row.base      = addr_reg;
                upd_row.pages     = size_reg;
                upd_row.flags     = '0;
                upd_row.serial    = serial_reg;
                upd_row.heap      = heap_reg;
                upd_row.owner     = owner_reg;
                upd_row.res_adds  = '0;
                upd_row.evictions = '0;
                upd_row.map_depth = '0;
                upd_row.t_create  = ts_reg;
                upd_row.t_res     = '0;
                upd_row.t_map     = '0;
                upd_row.t_unmap   = '0;
            end
            arat_pkg::OP_RESIDENT:
            begin
                upd_row.flags    = row_reg.flags | 5'b00011;
                upd_row.res_adds = row_reg.res_adds + 32'd1;
                upd_row.t_res    = ts_reg;
            end
            arat_pkg::OP_EVICT:
            begin
                upd_row.flags     = (row_reg.flags | 5'b00100) & 5'b11110;
                upd_row.evictions = row_reg.evictions + 32'd1;
                upd_row.t_res     = ts_reg;
            end
            arat_pkg::OP_MAP:
            begin
                upd_row.flags = row_reg.flags | 5'b11000;
                upd_row.t_map = ts_reg;
                if (row_reg.map_depth != '1)
                    upd_row.map_depth = row_reg.map_depth + 32'd1;
            end
            arat_pkg::OP_UNMAP:
            begin
                upd_row.flags   = row_reg.flags & 5'b10111;
                upd_row.t_unmap = ts_reg;
                if (row_reg.map_depth != '0)
                    upd_row.map_depth = row_reg.map_depth - 32'd1;
            end
            default:
                upd_row = row_reg;
        endcase
    end

    // outputs and datapath next values
    always_comb
    begin
        in_stall        = (state_reg != arat_pkg::S_IDLE);
        tbl_we          = 1'b0;
        tbl_widx        = upd_slot;
        tbl_wrow        = upd_row;
        idx_next        = idx_reg;
        cmp_vld_next    = 1'b0;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_idx_next    = hit_idx_reg;
        row_next        = row_reg;
        valid_next      = valid_reg;
        live_next       = live_reg;
        serial_next     = serial_reg;
        total_next      = total_reg;
        heap_sum_next   = heap_bytes_reg[upd_heap];
        res_next        = res_reg;

        // failure result: only status and the running total
        unique case (state_reg)
            arat_pkg::S_CHECK:
            begin
                idx_next        = '0;
                free_found_next = 1'b0;
                res_next        = '0;
                res_next.status = chk_status;
                res_next.total_bytes = total_reg;
            end
            arat_pkg::S_SCAN:
            begin
                idx_next     = idx_reg + IW'(1);
                cmp_vld_next = 1'b1;
                if (free_now && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (hit)
                begin
                    hit_idx_next = cmp_idx_reg;
                    row_next     = tbl_rrow;
                    if (is_add)
                        res_next.status = arat_pkg::ST_OVERLAP;
                end
                else if (last && !(is_add && (free_found_reg || free_now)))
                begin
                    res_next.status = is_add ? arat_pkg::ST_FULL
                                             : arat_pkg::ST_NOTFOUND;
                end
            end
            arat_pkg::S_UPDATE:
            begin
                unique case (op_reg)
                    arat_pkg::OP_ADD:
                    begin
                        tbl_we                = 1'b1;
                        valid_next[upd_slot]  = 1'b1;
                        live_next             = live_reg + arat_pkg::LIVE_W'(1);
                        serial_next           = serial_reg + 32'd1;
                        total_next            = total_reg + upd_bytes;
                        heap_sum_next         = heap_bytes_reg[upd_heap] + upd_bytes;
                    end
                    arat_pkg::OP_REMOVE:
                    begin
                        valid_next[upd_slot] = 1'b0;
                        if (live_reg != '0)
                            live_next = live_reg - arat_pkg::LIVE_W'(1);
                        total_next    = total_reg - upd_bytes;
                        heap_sum_next = heap_bytes_reg[upd_heap] - upd_bytes;
                    end
                    arat_pkg::OP_RESIDENT, arat_pkg::OP_EVICT,
                    arat_pkg::OP_MAP, arat_pkg::OP_UNMAP:
                        tbl_we = 1'b1;
                    default:
                        tbl_we = 1'b0;
                endcase
                res_next.status        = arat_pkg::ST_OK;
                res_next.entry_index   = 6'(upd_slot);
                res_next.serial        = upd_row.serial;
                res_next.flags         = upd_row.flags;
                res_next.resident_adds = upd_row.res_adds;
                res_next.evictions     = upd_row.evictions;
                res_next.map_depth     = upd_row.map_depth;
                res_next.range_base    = upd_row.base;
                res_next.range_pages   = upd_row.pages;
                res_next.total_bytes   = total_next;
                res_next.heap_bytes    = heap_sum_next;
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (state_reg == arat_pkg::S_DONE && (!out_valid_reg || !out_stall))
            out_valid_next = 1'b1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= arat_pkg::S_IDLE;
            limit_reg      <= arat_pkg::LIMIT_RESET;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            valid_reg      <= '0;
            live_reg       <= '0;
            serial_reg     <= '0;
            total_reg      <= '0;
            out_valid_reg  <= 1'b0;
            for (int h = 0; h < arat_pkg::HEAPS; h++)
            begin
                heap_bytes_reg[h] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            valid_reg      <= valid_next;
            live_reg       <= live_next;
            serial_reg     <= serial_next;
            total_reg      <= total_next;
            out_valid_reg  <= out_valid_next;
            heap_bytes_reg[upd_heap] <= heap_sum_next;
            if (cfg_write)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == arat_pkg::S_IDLE && in_valid)
        begin
            op_reg    <= in_item.operation;
            addr_reg  <= in_item.address;
            size_reg  <= in_item.size_pages;
            ts_reg    <= in_item.timestamp;
            heap_reg  <= in_item.preferred_heap;
            owner_reg <= in_item.owner;
        end
        idx_reg      <= idx_next;
        cmp_idx_reg  <= idx_reg;
        free_idx_reg <= free_idx_next;
        hit_idx_reg  <= hit_idx_next;
        row_reg      <= row_next;
        res_reg      <= res_next;
        if (state_reg == arat_pkg::S_DONE && (!out_valid_reg || !out_stall))
        begin
            out_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // live count tracks the valid bits
    a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(live_reg))
        else $error("live count does not match valid slots");

    // a new result only ever comes from the hand-over state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == arat_pkg::S_DONE))
        else $error("result raised outside hand-over");

    // the record store is only written during the update cycle
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> state_reg == arat_pkg::S_UPDATE)
        else $error("record store written outside update");

    // an update always follows a scan
    a_update_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == arat_pkg::S_UPDATE |-> $past(state_reg == arat_pkg::S_SCAN))
        else $error("update without scan");

endmodule

`default_nettype wire
